// ===== src/bmac_pkg.sv =====
// Shared types, register indexes, status codes and defaults for the boot manifest check.
// Used by bmac_capture, bmac_judge and boot_manifest_acceptance_check.
package bmac_pkg;

    // Default sizes handed to the top-level parameters
    localparam int MANIFEST_BYTES_DEF = 64;
    localparam int TRIAL_ATTEMPTS_DEF = 3;

    // Capture layout
    localparam int HDR_LEN   = 9;
    localparam int WORD_BASE = 12;
    localparam int WORD_LEN  = 16;
    localparam int CNT_W     = 7;
    localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

    // Manifest magic "BAU1"
    localparam logic [7:0] MAGIC_0 = 8'h42;
    localparam logic [7:0] MAGIC_1 = 8'h41;
    localparam logic [7:0] MAGIC_2 = 8'h55;
    localparam logic [7:0] MAGIC_3 = 8'h31;

    // Configuration register indexes
    localparam logic [2:0] REG_FAMILY_MASK    = 3'd0;
    localparam logic [2:0] REG_MAX_API_LEVEL  = 3'd1;
    localparam logic [2:0] REG_ACCEPTED_KEY   = 3'd2;
    localparam logic [2:0] REG_MAX_IMAGE      = 3'd3;
    localparam logic [2:0] REG_MAX_VALIDITY   = 3'd4;
    localparam logic [2:0] REG_CONFIRMED_VER  = 3'd5;
    localparam logic [2:0] REG_WIRE_FORMAT    = 3'd6;
    localparam logic [2:0] REG_SIGNED_LEN     = 3'd7;

    // Verdict codes
    typedef logic [2:0] status_t;
    localparam status_t ST_STAGED       = 3'd0;
    localparam status_t ST_TOO_SHORT    = 3'd1;
    localparam status_t ST_UNAUTHORIZED = 3'd2;
    localparam status_t ST_BAD_SHAPE    = 3'd3;
    localparam status_t ST_INCOMPATIBLE = 3'd4;
    localparam status_t ST_EXPIRED      = 3'd5;
    localparam status_t ST_ROLLBACK     = 3'd6;

    // Configuration register file contents
    typedef struct packed {
        logic [7:0]  family_mask;
        logic [7:0]  max_api_level;
        logic [7:0]  accepted_key_id;
        logic [31:0] max_image_bytes;
        logic [31:0] validity_limit;
        logic [31:0] version_floor;
        logic [7:0]  wire_format_version;
        logic [7:0]  signed_length_code;
    } cfg_t;

    // Register file contents after reset
    localparam cfg_t CFG_RESET = '{
        family_mask:         8'd0,
        max_api_level:       8'd0,
        accepted_key_id:     8'd0,
        max_image_bytes:     32'd0,
        validity_limit:      32'd0,
        version_floor:       32'd0,
        wire_format_version: 8'd1,
        signed_length_code:  8'd32
    };

    // Captured manifest fields; words little-endian, word k at bits 32k+31:32k
    typedef struct packed {
        logic [CNT_W-1:0]           count;
        logic [CNT_W-1:0]           len;
        logic [HDR_LEN-1:0][7:0]    header;
        logic [WORD_LEN-1:0][7:0]   words;
    } capture_t;

endpackage

// ===== src/bmac_capture.sv =====
// Byte counter and header/word capture for the boot manifest check.
// Depends on bmac_pkg.
module bmac_capture
    import bmac_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output capture_t   cap
);

    logic [CNT_W-1:0]         count_reg, count_next;
    logic [HDR_LEN-1:0][7:0]  header_reg, header_next;
    logic [WORD_LEN-1:0][7:0] words_reg, words_next;
    logic [CNT_W-1:0]         len;
    logic [CNT_W-1:0]         word_off;

    // Saturating length including the current byte
    assign len      = (count_reg < COUNT_MAX) ? count_reg + 7'd1 : COUNT_MAX;
    assign word_off = count_reg - CNT_W'(WORD_BASE);

    // Store the byte at its offset, clear everything after the last byte
    always_comb begin
        count_next  = count_reg;
        header_next = header_reg;
        words_next  = words_reg;
        if (advance) begin
            if (last_byte) begin
                count_next  = '0;
                header_next = '0;
                words_next  = '0;
            end else begin
                count_next = len;
                if (count_reg < CNT_W'(HDR_LEN)) begin
                    header_next[count_reg[3:0]] = data_byte;
                end else if (count_reg >= CNT_W'(WORD_BASE) &&
                             count_reg < CNT_W'(WORD_BASE + WORD_LEN)) begin
                    words_next[word_off[3:0]] = data_byte;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            header_reg <= '0;
            words_reg  <= '0;
        end else begin
            count_reg  <= count_next;
            header_reg <= header_next;
            words_reg  <= words_next;
        end
    end

    assign cap.count  = count_reg;
    assign cap.len    = len;
    assign cap.header = header_reg;
    assign cap.words  = words_reg;

endmodule

// ===== src/bmac_judge.sv =====
// Verdict logic: ordered checks of length, signature, shape, compatibility, limits,
// time window and rollback floor. Depends on bmac_pkg.
module bmac_judge
    import bmac_pkg::*;
#(
    parameter int MANIFEST_BYTES = MANIFEST_BYTES_DEF
) (
    input  capture_t    cap,
    input  cfg_t        cfg,
    input  logic        signature_ok,
    input  logic [31:0] now_ms,
    output status_t     status
);

    logic [31:0] version, image, start, span;
    logic [32:0] window_end;
    logic        short_len, bad_shape, incompat, over_limit, expired, rollback;

    assign version = cap.words[3:0];
    assign image   = cap.words[7:4];
    assign start   = cap.words[11:8];
    assign span    = cap.words[15:12];

    // Window end in 33 bits so it never wraps
    assign window_end = {1'b0, start} + {1'b0, span};

    assign short_len  = cap.len < CNT_W'(MANIFEST_BYTES);
    assign bad_shape  = cap.header[0] != MAGIC_0 || cap.header[1] != MAGIC_1 ||
                        cap.header[2] != MAGIC_2 || cap.header[3] != MAGIC_3 ||
                        cap.header[4] != cfg.wire_format_version ||
                        cap.header[5] != cfg.signed_length_code;
    assign incompat   = (cap.header[6] & cfg.family_mask) == 8'd0 ||
                        cap.header[7] > cfg.max_api_level ||
                        cap.header[8] != cfg.accepted_key_id;
    assign over_limit = image > cfg.max_image_bytes || span > cfg.validity_limit;
    assign expired    = now_ms < start || {1'b0, now_ms} >= window_end;
    assign rollback   = version < cfg.version_floor;

    // First failing check wins
    always_comb begin
        priority if (short_len) begin
            status = ST_TOO_SHORT;
        end else if (!signature_ok) begin
            status = ST_UNAUTHORIZED;
        end else if (bad_shape) begin
            status = ST_BAD_SHAPE;
        end else if (incompat) begin
            status = ST_INCOMPATIBLE;
        end else if (over_limit) begin
            status = ST_BAD_SHAPE;
        end else if (expired) begin
            status = ST_EXPIRED;
        end else if (rollback) begin
            status = ST_ROLLBACK;
        end else begin
            status = ST_STAGED;
        end
    end

endmodule

// ===== src/boot_manifest_acceptance_check.sv =====
// Top level of the boot manifest acceptance check with A/B slot staging.
// Depends on bmac_pkg, bmac_capture and bmac_judge.
//
// The block takes one manifest byte per cycle: each request is held in an input
// register, stored at its offset in the next cycle, and a byte marked last is
// judged as it leaves the input register, its verdict loaded into the result
// register in that same cycle. Only a last byte needs the result register; while
// that register holds an untaken verdict and the input register holds another
// last byte, the input stalls. Otherwise the rate is one byte per cycle. An
// accepted manifest flips the active slot and reports slot, trial attempts and
// version; a rejected one reports zeros and leaves the slot unchanged.
// Configuration writes are accepted every cycle.
module boot_manifest_acceptance_check
    import bmac_pkg::*;
#(
    parameter int MANIFEST_BYTES = MANIFEST_BYTES_DEF,
    parameter int TRIAL_ATTEMPTS = TRIAL_ATTEMPTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // manifest byte requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic        s_signature_ok,
    input  logic [31:0] s_now_ms,
    // verdicts
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_boot_slot,
    output logic [3:0]  m_trial_attempts,
    output logic [31:0] m_staged_version,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t        cfg_reg;
    logic        a_valid_reg, a_valid_next;
    logic [7:0]  a_data_reg;
    logic        a_last_reg, a_sig_reg;
    logic [31:0] a_now_reg;
    logic        a_advance, out_load;
    capture_t    cap;
    status_t     verdict;
    logic        active_slot_reg, active_slot_next;
    logic        m_valid_next;

    // Configuration register file
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FAMILY_MASK:   cfg_reg.family_mask         <= cfg_data[7:0];
                REG_MAX_API_LEVEL: cfg_reg.max_api_level       <= cfg_data[7:0];
                REG_ACCEPTED_KEY:  cfg_reg.accepted_key_id     <= cfg_data[7:0];
                REG_MAX_IMAGE:     cfg_reg.max_image_bytes     <= cfg_data;
                REG_MAX_VALIDITY:  cfg_reg.validity_limit      <= cfg_data;
                REG_CONFIRMED_VER: cfg_reg.version_floor       <= cfg_data;
                REG_WIRE_FORMAT:   cfg_reg.wire_format_version <= cfg_data[7:0];
                REG_SIGNED_LEN:    cfg_reg.signed_length_code  <= cfg_data[7:0];
            endcase
        end
    end

    // Input register advances unless a last byte waits on a full result register
    assign a_advance    = a_valid_reg && (!a_last_reg || !m_valid || m_ready);
    assign s_ready      = !a_valid_reg || a_advance;
    assign a_valid_next = s_valid ? 1'b1 : (a_advance ? 1'b0 : a_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_data_reg <= s_data_byte;
            a_last_reg <= s_last_byte;
            a_sig_reg  <= s_signature_ok;
            a_now_reg  <= s_now_ms;
        end
    end

    bmac_capture u_capture (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (a_advance),
        .data_byte (a_data_reg),
        .last_byte (a_last_reg),
        .cap       (cap)
    );

    bmac_judge #(
        .MANIFEST_BYTES (MANIFEST_BYTES)
    ) u_judge (
        .cap          (cap),
        .cfg          (cfg_reg),
        .signature_ok (a_sig_reg),
        .now_ms       (a_now_reg),
        .status       (verdict)
    );

    // Flip the active slot on a staged manifest
    assign out_load         = a_advance && a_last_reg;
    assign active_slot_next = (out_load && verdict == ST_STAGED) ? !active_slot_reg
                                                                 : active_slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_slot_reg <= 1'b0;
        end else begin
            active_slot_reg <= active_slot_next;
        end
    end

    // Result register
    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else begin
            m_valid <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status <= verdict;
            if (verdict == ST_STAGED) begin
                m_boot_slot      <= active_slot_next;
                m_trial_attempts <= 4'(TRIAL_ATTEMPTS);
                m_staged_version <= cap.words[3:0];
            end else begin
                m_boot_slot      <= 1'b0;
                m_trial_attempts <= 4'd0;
                m_staged_version <= 32'd0;
            end
        end
    end

`ifndef SYNTHESIS
    // Rejected verdicts carry no plan
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_STAGED) |->
        (!m_boot_slot && m_trial_attempts == 4'd0 && m_staged_version == 32'd0))
        else $error("plan fields nonzero on rejected manifest");

    // A staged verdict reports the slot that is now active
    a_slot_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && verdict == ST_STAGED) |=> (active_slot_reg == m_boot_slot))
        else $error("reported slot differs from active slot");

    // Capture restarts after every verdict
    a_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (cap.count == '0))
        else $error("byte count not cleared after last byte");

    // Input stalls only behind a pending verdict
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (a_valid_reg && a_last_reg && m_valid && !m_ready))
        else $error("input stalled without a waiting verdict");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for boot_manifest_acceptance_check: streams manifests byte by
// byte, predicts every verdict and the A/B slot plan, and compares each result field.
// Depends on bmac_pkg and the boot_manifest_acceptance_check RTL.
module testbench
    import bmac_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEM_TARGET     = 1600;
    localparam int MIN_PHASES      = 3;
    localparam int PHASE_MANIFESTS = 2;
    localparam int SETTLE_CYCLES   = 8;
    localparam int IDLE_PERCENT    = 37;

    // Manifest word slots, in offset order from WORD_BASE
    localparam int W_VERSION = 0;
    localparam int W_IMAGE   = 1;
    localparam int W_START   = 2;
    localparam int W_SPAN    = 3;

    // Ways a generated manifest can be broken
    typedef enum int {
        DEF_NONE, DEF_SHORT, DEF_SIG, DEF_MAGIC, DEF_WIRE, DEF_LENCODE, DEF_FAMILY,
        DEF_API, DEF_KEY, DEF_IMAGE, DEF_SPAN, DEF_EARLY, DEF_LATE, DEF_ROLLBACK,
        DEF_LONG
    } defect_t;

    typedef struct packed {
        status_t     status;
        logic        slot;
        logic [3:0]  attempts;
        logic [31:0] version;
    } verdict_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last_byte;
    logic        s_signature_ok;
    logic [31:0] s_now_ms;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic        m_boot_slot;
    logic [3:0]  m_trial_attempts;
    logic [31:0] m_staged_version;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // Predictor state
    cfg_t        cfg_shadow;
    logic [6:0]  man_count;
    logic [7:0]  man_hdr [HDR_LEN];
    logic [7:0]  man_word [WORD_LEN];
    logic        slot_active;
    verdict_t    pending_verdicts [$];

    // Manifest under construction
    logic [7:0]  mf_hdr [HDR_LEN];
    logic [31:0] mf_words [4];
    int          mf_len;
    logic        mf_sig;
    logic [31:0] mf_now;

    // Run control and bookkeeping
    bit          idle_on = 1'b1;
    int          hold_cycles = 0;
    int          errors = 0;
    int          cycle_count = 0;
    int          bytes_sent = 0;
    int          verdicts_seen = 0;
    int          staged_seen = 0;
    int          cfg_settings = 0;

    boot_manifest_acceptance_check dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .s_signature_ok   (s_signature_ok),
        .s_now_ms         (s_now_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_boot_slot      (m_boot_slot),
        .m_trial_attempts (m_trial_attempts),
        .m_staged_version (m_staged_version),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [31:0] rand_upto(logic [31:0] m);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 32'd0;
        if (pick == 1 || m == 32'd0) return m;
        if (m == 32'hFFFF_FFFF) return $urandom;
        return $urandom % (m + 32'd1);
    endfunction

    function automatic logic [31:0] word_of(int k);
        return {man_word[4*k+3], man_word[4*k+2], man_word[4*k+1], man_word[4*k]};
    endfunction

    // Apply the checks in priority order
    function automatic status_t verdict_for(logic [6:0] length, logic sig, logic [31:0] now);
        logic [32:0] window_end;
        if (int'(length) < MANIFEST_BYTES_DEF) return ST_TOO_SHORT;
        if (!sig) return ST_UNAUTHORIZED;
        if (man_hdr[0] != MAGIC_0 || man_hdr[1] != MAGIC_1 || man_hdr[2] != MAGIC_2 ||
            man_hdr[3] != MAGIC_3 || man_hdr[4] != cfg_shadow.wire_format_version ||
            man_hdr[5] != cfg_shadow.signed_length_code) return ST_BAD_SHAPE;
        if ((man_hdr[6] & cfg_shadow.family_mask) == 8'd0 ||
            man_hdr[7] > cfg_shadow.max_api_level ||
            man_hdr[8] != cfg_shadow.accepted_key_id) return ST_INCOMPATIBLE;
        if (word_of(W_IMAGE) > cfg_shadow.max_image_bytes ||
            word_of(W_SPAN) > cfg_shadow.validity_limit) return ST_BAD_SHAPE;
        window_end = {1'b0, word_of(W_START)} + {1'b0, word_of(W_SPAN)};
        if (now < word_of(W_START) || {1'b0, now} >= window_end) return ST_EXPIRED;
        if (word_of(W_VERSION) < cfg_shadow.version_floor) return ST_ROLLBACK;
        return ST_STAGED;
    endfunction

    task automatic clear_capture();
        man_count = '0;
        foreach (man_hdr[i]) man_hdr[i] = 8'd0;
        foreach (man_word[i]) man_word[i] = 8'd0;
    endtask

    task automatic reset_model();
        cfg_shadow = '0;
        cfg_shadow.wire_format_version = 8'd1;
        cfg_shadow.signed_length_code = 8'd32;
        slot_active = 1'b0;
        clear_capture();
    endtask

    // Capture one accepted byte; on the last byte queue the verdict
    task automatic predict_byte(logic [7:0] d, logic last, logic sig, logic [31:0] now);
        logic [6:0] pos;
        logic [6:0] length;
        verdict_t   v;
        pos = man_count;
        if (pos < HDR_LEN) man_hdr[pos] = d;
        else if (pos >= WORD_BASE && pos < WORD_BASE + WORD_LEN) man_word[pos - WORD_BASE] = d;
        length = (pos < COUNT_MAX) ? pos + 7'd1 : COUNT_MAX;
        if (!last) begin
            man_count = length;
        end else begin
            v = '0;
            v.status = verdict_for(length, sig, now);
            if (v.status == ST_STAGED) begin
                slot_active = ~slot_active;
                v.slot = slot_active;
                v.attempts = TRIAL_ATTEMPTS_DEF[3:0];
                v.version = word_of(W_VERSION);
            end
            pending_verdicts.push_back(v);
            clear_capture();
        end
    endtask

    // ---------------------------------------------------------------- drivers

    // Offer one byte request and hold it until taken
    task automatic send_req(logic [7:0] d, logic last, logic sig, logic [31:0] now);
        @(negedge aclk);
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= d;
        s_last_byte    <= last;
        s_signature_ok <= sig;
        s_now_ms       <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_byte(d, last, sig, now);
        bytes_sent++;
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Hold the sender until every verdict is back and the block is quiet
    task automatic wait_drain();
        release_input();
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_FAMILY_MASK:   cfg_shadow.family_mask = data[7:0];
            REG_MAX_API_LEVEL: cfg_shadow.max_api_level = data[7:0];
            REG_ACCEPTED_KEY:  cfg_shadow.accepted_key_id = data[7:0];
            REG_MAX_IMAGE:     cfg_shadow.max_image_bytes = data;
            REG_MAX_VALIDITY:  cfg_shadow.validity_limit = data;
            REG_CONFIRMED_VER: cfg_shadow.version_floor = data;
            REG_WIRE_FORMAT:   cfg_shadow.wire_format_version = data[7:0];
            REG_SIGNED_LEN:    cfg_shadow.signed_length_code = data[7:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Write all eight registers; narrow ones get junk in the upper bits
    task automatic program_config(cfg_t c);
        write_reg(REG_FAMILY_MASK,   {24'($urandom), c.family_mask});
        write_reg(REG_MAX_API_LEVEL, {24'($urandom), c.max_api_level});
        write_reg(REG_ACCEPTED_KEY,  {24'($urandom), c.accepted_key_id});
        write_reg(REG_MAX_IMAGE,     c.max_image_bytes);
        write_reg(REG_MAX_VALIDITY,  c.validity_limit);
        write_reg(REG_CONFIRMED_VER, c.version_floor);
        write_reg(REG_WIRE_FORMAT,   {24'($urandom), c.wire_format_version});
        write_reg(REG_SIGNED_LEN,    {24'($urandom), c.signed_length_code});
        cfg_settings++;
    endtask

    // ---------------------------------------------------------------- manifests

    // Build a manifest passing current settings unless family mask or span is zero
    task automatic make_good_manifest();
        logic [7:0]  fam;
        logic [31:0] start;
        logic [31:0] span;
        logic [31:0] off;
        mf_hdr[0] = MAGIC_0;
        mf_hdr[1] = MAGIC_1;
        mf_hdr[2] = MAGIC_2;
        mf_hdr[3] = MAGIC_3;
        mf_hdr[4] = cfg_shadow.wire_format_version;
        mf_hdr[5] = cfg_shadow.signed_length_code;
        fam = 8'($urandom) & cfg_shadow.family_mask;
        if (fam == 8'd0) fam = cfg_shadow.family_mask & (~cfg_shadow.family_mask + 8'd1);
        if (cfg_shadow.family_mask == 8'd0) fam = 8'($urandom);
        mf_hdr[6] = fam;
        mf_hdr[7] = 8'(rand_upto({24'd0, cfg_shadow.max_api_level}));
        mf_hdr[8] = cfg_shadow.accepted_key_id;
        mf_words[W_VERSION] = cfg_shadow.version_floor +
                              rand_upto(~cfg_shadow.version_floor);
        mf_words[W_IMAGE] = rand_upto(cfg_shadow.max_image_bytes);
        span = rand_upto(cfg_shadow.validity_limit);
        start = rand_upto(32'hFFFF_FFFF);
        mf_words[W_START] = start;
        mf_words[W_SPAN] = span;
        // Place now inside the window, clipped to 32 bits
        if (span == 32'd0) begin
            off = 32'd0;
        end else begin
            off = rand_upto(span - 32'd1);
            if (off > ~start) off = ~start;
        end
        mf_now = start + off;
        mf_sig = 1'b1;
        mf_len = ($urandom_range(0, 4) == 0) ? $urandom_range(65, 72) : MANIFEST_BYTES_DEF;
    endtask

    task automatic apply_defect(defect_t kind);
        logic [32:0] window_end;
        case (kind)
            DEF_SHORT:   mf_len = $urandom_range(1, MANIFEST_BYTES_DEF - 1);
            DEF_SIG:     mf_sig = 1'b0;
            DEF_MAGIC:   mf_hdr[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
            DEF_WIRE:    mf_hdr[4] ^= 8'($urandom_range(1, 255));
            DEF_LENCODE: mf_hdr[5] ^= 8'($urandom_range(1, 255));
            DEF_FAMILY:  mf_hdr[6] = 8'($urandom) & ~cfg_shadow.family_mask;
            DEF_API: begin
                if (cfg_shadow.max_api_level != 8'hFF)
                    mf_hdr[7] = 8'($urandom_range(cfg_shadow.max_api_level + 1, 255));
            end
            DEF_KEY:     mf_hdr[8] ^= 8'($urandom_range(1, 255));
            DEF_IMAGE: begin
                if (cfg_shadow.max_image_bytes != 32'hFFFF_FFFF)
                    mf_words[W_IMAGE] = cfg_shadow.max_image_bytes + 32'd1 +
                                        rand_upto(~cfg_shadow.max_image_bytes - 32'd1);
            end
            DEF_SPAN: begin
                if (cfg_shadow.validity_limit != 32'hFFFF_FFFF)
                    mf_words[W_SPAN] = cfg_shadow.validity_limit + 32'd1 +
                                       rand_upto(~cfg_shadow.validity_limit - 32'd1);
            end
            DEF_EARLY: begin
                if (mf_words[W_START] != 32'd0)
                    mf_now = mf_words[W_START] - 32'd1 - rand_upto(mf_words[W_START] - 32'd1);
            end
            DEF_LATE: begin
                window_end = {1'b0, mf_words[W_START]} + {1'b0, mf_words[W_SPAN]};
                if (!window_end[32])
                    mf_now = window_end[31:0] + rand_upto(32'hFFFF_FFFF - window_end[31:0]);
            end
            DEF_ROLLBACK: begin
                if (cfg_shadow.version_floor != 32'd0)
                    mf_words[W_VERSION] = cfg_shadow.version_floor - 32'd1 -
                                          rand_upto(cfg_shadow.version_floor - 32'd1);
            end
            DEF_LONG:    mf_len = $urandom_range(100, 140);
            default: ;
        endcase
    endtask

    // Stream the built manifest; uncaptured offsets carry random bytes
    task automatic send_manifest();
        logic [7:0] b;
        logic       last;
        int         w;
        for (int i = 0; i < mf_len; i++) begin
            b = 8'($urandom);
            w = i - WORD_BASE;
            if (i < HDR_LEN) b = mf_hdr[i];
            else if (w >= 0 && w < WORD_LEN) b = mf_words[w / 4][8 * (w % 4) +: 8];
            last = (i == mf_len - 1);
            send_req(b, last, last ? mf_sig : 1'($urandom_range(0, 1)),
                     last ? mf_now : $urandom);
        end
    endtask

    // Half clean manifests, the other half broken in one or two ways
    task automatic random_manifest();
        make_good_manifest();
        if ($urandom_range(0, 99) < 50) begin
            apply_defect(defect_t'($urandom_range(DEF_SHORT, DEF_LONG)));
            if ($urandom_range(0, 99) < 30)
                apply_defect(defect_t'($urandom_range(DEF_SHORT, DEF_LONG)));
        end
        send_manifest();
    endtask

    // ---------------------------------------------------------------- checker

    task automatic check_field(string name, logic [31:0] expv, logic [31:0] got);
        if (expv !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, expv, got);
            errors++;
        end
    endtask

    // Compare each taken verdict with the oldest prediction
    always @(posedge aclk) begin
        verdict_t v;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected verdict, expected none actual status %0d",
                         $time, m_status);
                errors++;
            end else begin
                v = pending_verdicts.pop_front();
                check_field("status", 32'(v.status), 32'(m_status));
                check_field("boot_slot", 32'(v.slot), 32'(m_boot_slot));
                check_field("trial_attempts", 32'(v.attempts), 32'(m_trial_attempts));
                check_field("staged_version", v.version, m_staged_version);
                verdicts_seen++;
                if (v.status == ST_STAGED) staged_seen++;
            end
        end
    end

    // Result side: random stalls, or a counted hold-off when asked
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // Reset register values: short manifest, one failing on family mask zero, one bad wire format
    task automatic test_reset_defaults();
        make_good_manifest();
        mf_len = 1;
        send_manifest();
        make_good_manifest();
        send_manifest();
        make_good_manifest();
        mf_hdr[4] = 8'd0;
        send_manifest();
    endtask

    // One manifest per rejection path, slot flips and window edge cases
    task automatic test_directed_verdicts();
        cfg_t c;
        wait_drain();
        c = '0;
        c.family_mask = 8'h5A;
        c.max_api_level = 8'h40;
        c.accepted_key_id = 8'hC3;
        c.max_image_bytes = 32'h0010_0000;
        c.validity_limit = 32'h0001_0000;
        c.version_floor = 32'h0000_0100;
        c.wire_format_version = 8'h02;
        c.signed_length_code = 8'h20;
        program_config(c);
        for (int k = DEF_NONE; k <= DEF_LONG; k++) begin
            make_good_manifest();
            apply_defect(defect_t'(k));
            send_manifest();
        end
        // Window end beyond 32 bits must not wrap
        make_good_manifest();
        mf_words[W_START] = 32'hFFFF_FFF0;
        mf_words[W_SPAN] = 32'h0000_0100;
        mf_now = 32'hFFFF_FFFF;
        send_manifest();
        // Time zero at the window start, top version
        make_good_manifest();
        mf_words[W_START] = 32'd0;
        mf_words[W_SPAN] = 32'd1;
        mf_now = 32'd0;
        mf_words[W_VERSION] = 32'hFFFF_FFFF;
        send_manifest();
        // Exact limits on every field
        make_good_manifest();
        mf_hdr[7] = c.max_api_level;
        mf_words[W_IMAGE] = c.max_image_bytes;
        mf_words[W_SPAN] = c.validity_limit;
        mf_words[W_VERSION] = c.version_floor;
        mf_words[W_START] = 32'h1000_0000;
        mf_now = 32'h1000_0000 + c.validity_limit - 32'd1;
        send_manifest();
    endtask

    // Back-to-back stream with no stalls on either side
    task automatic test_no_idle_stream();
        wait_drain();
        idle_on = 1'b0;
        repeat (2) random_manifest();
        wait_drain();
        idle_on = 1'b1;
    endtask

    // Receiver stalls long while short manifests pile up at the input
    task automatic test_backpressure();
        @(posedge aclk);
        hold_cycles = 400;
        repeat (12) begin
            make_good_manifest();
            mf_len = $urandom_range(1, 3);
            send_manifest();
        end
        wait_drain();
    endtask

    // Random settings, extremes first, each followed by a few manifests
    task automatic test_random_phases();
        cfg_t c;
        int   phase;
        phase = 0;
        while (phase < MIN_PHASES || bytes_sent < ITEM_TARGET) begin
            wait_drain();
            if (phase == 0) begin
                c = '1;
            end else if (phase == 1) begin
                c = '0;
            end else begin
                c.family_mask = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
                c.max_api_level = 8'($urandom);
                c.accepted_key_id = 8'($urandom);
                c.max_image_bytes = rand_upto(32'hFFFF_FFFF);
                c.validity_limit = rand_upto(32'hFFFF_FFFF);
                c.version_floor = ($urandom_range(0, 3) == 0) ? $urandom
                                                              : $urandom_range(0, 1000);
                c.wire_format_version = 8'($urandom);
                c.signed_length_code = 8'($urandom);
            end
            program_config(c);
            repeat (PHASE_MANIFESTS) random_manifest();
            phase++;
        end
        wait_drain();
    endtask

    // ---------------------------------------------------------------- main

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data_byte = 8'd0;
        s_last_byte = 1'b0;
        s_signature_ok = 1'b0;
        s_now_ms = 32'd0;
        cfg_valid = 1'b0;
        cfg_index = 3'd0;
        cfg_data = 32'd0;
        reset_model();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_directed_verdicts();
        test_no_idle_stream();
        test_backpressure();
        test_random_phases();
        wait_drain();

        $display("Streamed %0d manifest bytes; checked %0d verdicts, %0d of them staged",
                 bytes_sent, verdicts_seen, staged_seen);
        $display("Covered reset defaults, every rejection path, slot flips, stalls and %0d settings",
                 cfg_settings);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bmac_pkg.sv
src/bmac_capture.sv
src/bmac_judge.sv
src/boot_manifest_acceptance_check.sv
tb/testbench.sv
